[hw/rtl/grid_scan_order_reorder_defines.svh]
// grid_scan_order_reorder_defines.svh
// assertion macros for the checker file of the grid reorder block
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef GRID_SCAN_ORDER_REORDER_DEFINES_SVH
`define GRID_SCAN_ORDER_REORDER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define GSOR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GSOR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gsor_pkg.sv]
// gsor_pkg.sv
// shared constants and types of the grid scan-order reorder block
// no dependencies
package gsor_pkg;

    // default sizing
    localparam int MAX_DIM_DEF   = 512;
    localparam int WORD_BITS_DEF = 32;

    // configuration port
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int FLAGS_W    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_FLAGS = 2'd2;

    // scan flag bit positions
    localparam int FLAG_COL_REV   = 7;
    localparam int FLAG_ROW_FWD   = 6;
    localparam int FLAG_COL_MAJOR = 5;

    // result status codes
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_DATA     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EARLY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // commands from the top level to the drain address generator
    typedef struct packed {
        logic clear;  // re-arm: counters back to the first point
        logic step;   // one word drained, advance
    } t_drain_cmd;

endpackage

[hw/rtl/gsor_ram.sv]
// gsor_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module gsor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/gsor_agen.sv]
// gsor_agen.sv
// drain address generator: row and column counters and source address
// depends on gsor_pkg
module gsor_agen #(
    parameter int MAX_DIM = gsor_pkg::MAX_DIM_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gsor_pkg::t_drain_cmd                 i_cmd,
    input  logic [$clog2(MAX_DIM+1)-1:0]         i_cols,
    input  logic [$clog2(MAX_DIM+1)-1:0]         i_rows,
    input  logic [gsor_pkg::FLAGS_W-1:0]         i_flags,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_addr,
    output logic                                 o_fin
);
    import gsor_pkg::*;

    localparam int DW     = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int PW     = DW + IDX_W;

    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [DW-1:0]    rows_m1, cols_m1;
    logic [DW-1:0]    row_rev, col_rev;
    logic [IDX_W-1:0] row_sel, col_sel;
    logic             col_major;
    logic [DW-1:0]    mul_a;
    logic [IDX_W-1:0] mul_b, add_b;
    logic [PW-1:0]    prod, sum;
    logic             row_end;

    // last point of the row and of the grid
    assign rows_m1 = i_rows - DW'(1);
    assign cols_m1 = i_cols - DW'(1);
    assign row_end = (r_col == IDX_W'(cols_m1));
    assign o_fin   = row_end && (r_row == IDX_W'(rows_m1));

    // loop directions
    assign row_rev = rows_m1 - DW'(r_row);
    assign col_rev = cols_m1 - DW'(r_col);
    assign row_sel = i_flags[FLAG_ROW_FWD] ? r_row : IDX_W'(row_rev);
    assign col_sel = i_flags[FLAG_COL_REV] ? IDX_W'(col_rev) : r_col;

    // source address: rows*col+row or cols*row+col, one shared multiplier
    assign col_major = i_flags[FLAG_COL_MAJOR];
    assign mul_a     = col_major ? i_rows : i_cols;
    assign mul_b     = col_major ? col_sel : row_sel;
    assign add_b     = col_major ? row_sel : col_sel;
    assign prod      = PW'(mul_a) * PW'(mul_b);
    assign sum       = prod + PW'(add_b);
    assign o_addr    = sum[ADDR_W-1:0];

    // counter advance
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        priority if (i_cmd.clear || (i_cmd.step && o_fin)) begin
            n_row = '0;
            n_col = '0;
        end else if (i_cmd.step && row_end) begin
            n_col = '0;
            n_row = r_row + IDX_W'(1);
        end else if (i_cmd.step) begin
            n_col = r_col + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

[hw/rtl/grid_scan_order_reorder.sv]
// grid_scan_order_reorder.sv
// top level: load counter, grid store, result stage, configuration registers
// depends on gsor_pkg, gsor_ram, gsor_agen
//
//  channel  | direction | handshake
//  ---------+-----------+-----------------------------------------------
//  item     | in        | start high while busy low takes one word
//  result   | out       | o_valid strobe, one cycle, cannot be held off
//  config   | in        | i_cfg_we writes i_cfg_idx / i_cfg_data at once
//
// one word per cycle; drains and refused loads get a result the cycle after
// the word, set by the registered read of the grid store. busy is high only
// in the cycle after reset. reset clears counters and configuration, not the
// grid store. the receiver cannot stall, so nothing ever backs up.
module grid_scan_order_reorder #(
    parameter int MAX_DIM   = gsor_pkg::MAX_DIM_DEF,
    parameter int WORD_BITS = gsor_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [WORD_BITS-1:0]              i_word_in,
    // result channel
    output logic                              o_valid,
    output logic [WORD_BITS-1:0]              o_word_out,
    output logic                              o_last,
    output logic [gsor_pkg::STATUS_W-1:0]     o_status,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [gsor_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gsor_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gsor_pkg::*;

    localparam int DW     = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int TW     = 2 * DW;

    logic [CFG_DATA_W-1:0] r_cfg_cols, r_cfg_rows;
    logic [FLAGS_W-1:0]    r_flags;
    logic [DW-1:0]         eff_cols, eff_rows;
    logic [TW-1:0]         total;
    logic [CNT_W-1:0]      r_load_count, n_load_count;
    logic                  grid_full;
    logic                  accept, cfg_hit;
    logic                  r_busy;
    logic                  ram_we;
    logic [ADDR_W-1:0]     drain_addr;
    logic                  drain_fin;
    logic [WORD_BITS-1:0]  ram_q;
    t_drain_cmd            drain_cmd;
    logic                  r_valid, n_valid;
    logic                  r_last, n_last;
    logic [STATUS_W-1:0]   r_status, n_status;

    // configuration registers
    assign cfg_hit = i_cfg_we && ((i_cfg_idx == REG_GRID_COLS) ||
                                  (i_cfg_idx == REG_GRID_ROWS) ||
                                  (i_cfg_idx == REG_SCAN_FLAGS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= CFG_DATA_W'(1);
            r_cfg_rows <= CFG_DATA_W'(1);
            r_flags    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRID_COLS:  r_cfg_cols <= i_cfg_data;
                REG_GRID_ROWS:  r_cfg_rows <= i_cfg_data;
                REG_SCAN_FLAGS: r_flags    <= i_cfg_data[FLAGS_W-1:0];
                default: ;
            endcase
        end
    end

    // dimensions clamped to 1..MAX_DIM
    always_comb begin
        priority if (r_cfg_cols == '0) begin
            eff_cols = DW'(1);
        end else if (32'(r_cfg_cols) > MAX_DIM) begin
            eff_cols = DW'(MAX_DIM);
        end else begin
            eff_cols = DW'(r_cfg_cols);
        end
        priority if (r_cfg_rows == '0) begin
            eff_rows = DW'(1);
        end else if (32'(r_cfg_rows) > MAX_DIM) begin
            eff_rows = DW'(MAX_DIM);
        end else begin
            eff_rows = DW'(r_cfg_rows);
        end
    end

    assign total     = TW'(eff_cols) * TW'(eff_rows);
    assign grid_full = (TW'(r_load_count) >= total);

    // busy for one cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // item decode: load writes at the load count, drain reads the scan address
    always_comb begin
        ram_we          = 1'b0;
        n_load_count    = r_load_count;
        drain_cmd.clear = cfg_hit;
        drain_cmd.step  = 1'b0;
        n_valid         = 1'b0;
        n_last          = 1'b0;
        n_status        = ST_DATA;
        if (accept) begin
            n_valid = 1'b1;
            priority if (!i_func && grid_full) begin
                n_status = ST_OVERFLOW;
            end else if (!i_func) begin
                n_valid      = 1'b0;
                ram_we       = 1'b1;
                n_load_count = r_load_count + CNT_W'(1);
            end else if (!grid_full) begin
                n_status = ST_EARLY;
            end else begin
                drain_cmd.step = 1'b1;
                n_last         = drain_fin;
                if (drain_fin) begin
                    n_load_count = '0;
                end
            end
        end
        if (cfg_hit) begin
            n_load_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_load_count <= n_load_count;
            r_valid      <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_status <= n_status;
    end

    gsor_agen #(
        .MAX_DIM (MAX_DIM)
    ) u_agen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (drain_cmd),
        .i_cols  (eff_cols),
        .i_rows  (eff_rows),
        .i_flags (r_flags),
        .o_addr  (drain_addr),
        .o_fin   (drain_fin)
    );

    gsor_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load_count[ADDR_W-1:0]),
        .i_wdata (i_word_in),
        .i_raddr (drain_addr),
        .o_rdata (ram_q)
    );

    // error results carry a zero word
    assign o_valid    = r_valid;
    assign o_last     = r_last;
    assign o_status   = r_status;
    assign o_word_out = (r_status == ST_DATA) ? ram_q : '0;

endmodule

[hw/rtl/gsor_chk.sv]
// gsor_chk.sv
// port-level checker for the grid reorder block, bound to the top level
// depends on gsor_pkg and grid_scan_order_reorder_defines.svh
`include "grid_scan_order_reorder_defines.svh"

module gsor_chk #(
    parameter int WORD_BITS = gsor_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            i_func,
    input  logic                            o_valid,
    input  logic [WORD_BITS-1:0]            o_word_out,
    input  logic                            o_last,
    input  logic [gsor_pkg::STATUS_W-1:0]   o_status
);
    import gsor_pkg::*;

    // every drain word gets a result in the next cycle
    `GSOR_ASSERT_NXT(a_drain_answers, start && !busy && i_func, o_valid, "drain word not answered")

    // a result follows an accepted word
    `GSOR_ASSERT_IMP(a_no_spurious, o_valid, $past(start && !busy), "result without an accepted word")

    // data results come only from drains
    `GSOR_ASSERT_IMP(a_data_from_drain, o_valid && (o_status == ST_DATA), $past(i_func), "data result from a load")

    // error results carry a zero word and no last flag
    `GSOR_ASSERT_IMP(a_error_clean, o_valid && (o_status != ST_DATA), (o_word_out == '0) && !o_last, "error result not clean")

endmodule

bind grid_scan_order_reorder gsor_chk #(.WORD_BITS(WORD_BITS)) u_gsor_chk (.*);
